/* src/fma_pkg.sv */
// Shared types and constants for the first-fit memory allocator.
// Used by the top level and by its port checker; depends on nothing.
package fma_pkg;

  localparam int BaseW  = 10;
  localparam int SizeW  = 11;
  localparam int StartW = 10;

  localparam logic [BaseW-1:0] BASE_RESET = 10'd100;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  // Input tdata: request_size, free_start, zero pad to 24 bits.
  localparam int InDataW  = 24;
  // Output tdata: success, granted_start, zero pad to 16 bits.
  localparam int OutDataW = 16;

endpackage

/* src/fma_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependencies.
module fma_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/first_fit_memory_allocator_unit.sv */
// First-fit contiguous allocator top level: sequencer, pointer unit and used map.
// Depends on fma_pkg and fma_ram.
//
// Channel | Direction | Handshake            | Payload
// in_     | slave     | in_tvalid/in_tready  | tuser cmd, tdata size and free start
// out_    | master    | out_tvalid/out_tready| tdata success and granted start
// cfg_    | slave     | cfg_valid/cfg_ready  | cfg_data base address
//
// An allocate scans from the base, then marks the run it found as used; the
// scan visits one map unit per cycle through the single RAM read port.
// A free clears its units, one RAM write per unit.
// After reset a clearing pass writes every map unit before the first item is
// accepted. A waiting result still lets the next item in; that
// item's result then waits in the done state with in_tready low.
module first_fit_memory_allocator_unit #(
  parameter int MEM_UNITS = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [fma_pkg::InDataW-1:0]  in_tdata,   // [10:0] request_size, [20:11] free_start
  input  logic                         in_tuser,   // [0] cmd
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [fma_pkg::OutDataW-1:0] out_tdata,  // [0] success, [10:1] granted_start
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fma_pkg::BaseW-1:0]    cfg_data
);
  import fma_pkg::*;

  localparam int AW = (MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1;
  localparam int IW = (AW + 1 > 12) ? AW + 1 : 12;
  localparam logic [IW-1:0] MEM_END = IW'(MEM_UNITS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [BaseW-1:0]   base_r, base_nxt;
  logic [IW-1:0]      ptr_r, ptr_nxt;
  logic [IW-1:0]      end_r, end_nxt;
  logic [IW-1:0]      size_r, size_nxt;
  logic [IW-1:0]      run_len_r, run_len_nxt;
  logic [IW-1:0]      run_start_r, run_start_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic               pend_r, pend_nxt;
  logic               wr_val_r, wr_val_nxt;
  logic               ok_r, ok_nxt;
  logic [StartW-1:0]  start_r, start_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [StartW-1:0]  out_start_r, out_start_nxt;

  logic               ram_we, ram_wdata, ram_re, ram_rdata;
  logic               ptr_below;
  logic [IW-1:0]      in_size, in_fstart, in_lo, in_end, cand, cand_len;
  cmd_t               in_cmd;

  // The one pointer compare shared by scanning, marking and freeing.
  assign ptr_below = (ptr_r < end_r);

  assign in_cmd    = cmd_t'(in_tuser);
  assign in_size   = IW'(in_tdata[SizeW-1:0]);
  assign in_fstart = IW'(in_tdata[SizeW+StartW-1:SizeW]);
  assign in_lo     = (in_fstart < IW'(base_r)) ? IW'(base_r) : in_fstart;
  assign in_end    = ((in_fstart + in_size) > MEM_END) ? MEM_END : (in_fstart + in_size);
  assign cand      = (run_len_r == '0) ? IW'(pos_r) : run_start_r;
  assign cand_len  = run_len_r + IW'(1);

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OutDataW - StartW - 1){1'b0}}, out_start_r, out_ok_r};

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    ptr_nxt       = ptr_r;
    end_nxt       = end_r;
    size_nxt      = size_r;
    run_len_nxt   = run_len_r;
    run_start_nxt = run_start_r;
    pos_nxt       = pos_r;
    pend_nxt      = 1'b0;
    wr_val_nxt    = wr_val_r;
    ok_nxt        = ok_r;
    start_nxt     = start_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_ok_nxt    = out_ok_r;
    out_start_nxt = out_start_r;
    ram_we        = 1'b0;
    ram_wdata     = wr_val_r;
    ram_re        = 1'b0;

    if (cfg_valid) begin
      base_nxt = cfg_data;
    end

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = 1'b0;
        ptr_nxt   = ptr_r + IW'(1);
        if (ptr_r == MEM_END - IW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          size_nxt = in_size;
          if (in_cmd == CMD_FREE) begin
            ptr_nxt    = in_lo;
            end_nxt    = in_end;
            wr_val_nxt = 1'b0;
            ok_nxt     = 1'b1;
            start_nxt  = '0;
            state_nxt  = ST_WRITE;
          end else if (in_size == '0) begin
            ok_nxt    = 1'b0;
            start_nxt = '0;
            state_nxt = ST_DONE;
          end else begin
            ptr_nxt     = IW'(base_r);
            end_nxt     = MEM_END;
            run_len_nxt = '0;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (pend_r && !ram_rdata && (cand_len >= size_r)) begin
          // Run long enough: mark it used from its first unit.
          ptr_nxt    = cand;
          end_nxt    = cand + size_r;
          wr_val_nxt = 1'b1;
          ok_nxt     = 1'b1;
          start_nxt  = StartW'(cand);
          state_nxt  = ST_WRITE;
        end else begin
          if (pend_r) begin
            if (ram_rdata) begin
              run_len_nxt = '0;
            end else begin
              run_start_nxt = cand;
              run_len_nxt   = cand_len;
            end
          end
          if (ptr_below) begin
            ram_re   = 1'b1;
            pos_nxt  = ptr_r[AW-1:0];
            pend_nxt = 1'b1;
            ptr_nxt  = ptr_r + IW'(1);
          end else if (!pend_r) begin
            ok_nxt    = 1'b0;
            start_nxt = '0;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_WRITE: begin
        if (ptr_below) begin
          ram_we  = 1'b1;
          ptr_nxt = ptr_r + IW'(1);
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt   = 1'b1;
          out_ok_nxt    = ok_r;
          out_start_nxt = start_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      base_r    <= BASE_RESET;
      ptr_r     <= '0;
      end_r     <= MEM_END;
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      base_r    <= base_nxt;
      ptr_r     <= ptr_nxt;
      end_r     <= end_nxt;
      pend_r    <= pend_nxt;
      out_vld_r <= out_vld_nxt;
    end
    size_r      <= size_nxt;
    run_len_r   <= run_len_nxt;
    run_start_r <= run_start_nxt;
    pos_r       <= pos_nxt;
    wr_val_r    <= wr_val_nxt;
    ok_r        <= ok_nxt;
    start_r     <= start_nxt;
    out_ok_r    <= out_ok_nxt;
    out_start_r <= out_start_nxt;
  end

  fma_ram #(
    .WIDTH (1),
    .DEPTH (MEM_UNITS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r[AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ptr_r[AW-1:0]),
    .rdata (ram_rdata)
  );

endmodule

/* src/fma_checker.sv */
// Port-level checker for the first-fit allocator, bound to the top level.
// Depends on fma_pkg for the channel widths.
module fma_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [fma_pkg::OutDataW-1:0] out_tdata
);
  import fma_pkg::*;

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // A nonzero start unit is only reported with success.
  a_start_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[StartW:1] != '0) |-> out_tdata[0])
    else $error("start unit given on a failed item");

  // The map clearing pass follows reset, so no item is taken right after it.
  a_clear: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input ready during map clearing");

  // An accepted item occupies the sequencer for at least the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an accepted item");

endmodule

bind first_fit_memory_allocator_unit fma_checker u_fma_checker (.*);
